// ===== hdl/sep_pkg.sv =====
// Shared types, constants and helpers for the SSE event stream parser.
package sep_pkg;

    // Capacity of stored event name and id
    localparam int NAME_MAX = 16;
    localparam int ID_MAX   = 32;

    localparam int NLEN_W  = $clog2(NAME_MAX + 1);
    localparam int ILEN_W  = $clog2(ID_MAX + 1);
    localparam int IDX_MAX = (NAME_MAX > ID_MAX) ? NAME_MAX : ID_MAX;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);

    // Byte buffer: two id banks followed by the event name
    localparam int MEM_DEPTH = 2 * ID_MAX + NAME_MAX;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int NAME_BASE = 2 * ID_MAX;

    // Field-name buffer
    localparam int FN_MAX = 5;
    localparam logic [2:0] FN_LONG = 3'd6;

    // Stream bytes
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    // Result kinds
    localparam logic [1:0] K_DATA = 2'd0;
    localparam logic [1:0] K_NAME = 2'd1;
    localparam logic [1:0] K_ID   = 2'd2;
    localparam logic [1:0] K_END  = 2'd3;

    // Request types
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic [2:0] MSG_LAST = 3'd6;

    typedef enum logic [1:0] {
        FLD_NONE  = 2'd0,
        FLD_EVENT = 2'd1,
        FLD_DATA  = 2'd2,
        FLD_ID    = 2'd3
    } t_field;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_VSTART = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_SKIP   = 5'b10000
    } t_phase;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CR    = 11'b00000000010,
        S_BYTE  = 11'b00000000100,
        S_LEND  = 11'b00000001000,
        S_MSG   = 11'b00000010000,
        S_NRD   = 11'b00000100000,
        S_NEM   = 11'b00001000000,
        S_IRD   = 11'b00010000000,
        S_IEM   = 11'b00100000000,
        S_END   = 11'b01000000000,
        S_FLUSH = 11'b10000000000
    } t_state;

    typedef logic [FN_MAX-1:0][7:0] t_fname;

    // Result request from the sequencer to the output stage
    typedef struct packed {
        logic       valid;
        logic       flush;
        logic [1:0] kind;
        logic [7:0] value;
        logic       cut;
    } t_push;

    // Output stage status back to the sequencer
    typedef struct packed {
        logic push_ready;
        logic flush_done;
        logic hold_valid;
    } t_ost;

    // Match the collected field name against the known fields
    function automatic t_field classify(input t_fname fn, input logic [2:0] len);
        t_field f;
        f = FLD_NONE;
        if (len == 3'd5 && fn[0] == "e" && fn[1] == "v" && fn[2] == "e"
            && fn[3] == "n" && fn[4] == "t") begin
            f = FLD_EVENT;
        end else if (len == 3'd4 && fn[0] == "d" && fn[1] == "a" && fn[2] == "t"
            && fn[3] == "a") begin
            f = FLD_DATA;
        end else if (len == 3'd2 && fn[0] == "i" && fn[1] == "d") begin
            f = FLD_ID;
        end
        return f;
    endfunction

    // Default event name
    function automatic logic [7:0] msg_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "m";
            3'd1: c = "e";
            3'd2: c = "s";
            3'd3: c = "s";
            3'd4: c = "a";
            3'd5: c = "g";
            3'd6: c = "e";
            default: c = CHR_NUL;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/sep_buf.sv =====
// Byte buffer holding the two id banks and the event name.
module sep_buf (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [sep_pkg::MEM_AW-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic [sep_pkg::MEM_AW-1:0] i_raddr,
    output logic [7:0]                o_rdata
);

    logic [7:0] r_mem [sep_pkg::MEM_DEPTH];
    logic [7:0] r_rdata;

    // Write one byte, read one byte registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sep_out.sv =====
// Output stage: one held result plus the master-side output register.
module sep_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sep_pkg::t_push     i_push,
    output sep_pkg::t_ost      o_st,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [7:0]         o_tdata,
    output logic [2:0]         o_tuser,
    output logic               o_tlast
);

    logic       r_hold_v;
    logic [1:0] r_hold_kind;
    logic [7:0] r_hold_value;
    logic       r_hold_cut;
    logic       r_out_v;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_value;
    logic       r_out_cut;
    logic       r_out_last;
    logic       out_free;
    logic       push_ok;
    logic       flush_ok;

    assign out_free = !r_out_v || i_tready;
    assign push_ok  = !r_hold_v || out_free;
    assign flush_ok = !r_hold_v || out_free;

    // Control: hold slot and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_push.valid && push_ok) begin
                if (r_hold_v) begin
                    r_out_v <= 1'b1;
                end
                r_hold_v <= 1'b1;
            end else if (i_push.flush && r_hold_v && out_free) begin
                r_out_v  <= 1'b1;
                r_hold_v <= 1'b0;
            end
        end
    end

    // Payload: a newer result marks the held one as not last
    always_ff @(posedge i_clk) begin
        if (i_push.valid && push_ok) begin
            if (r_hold_v) begin
                r_out_kind  <= r_hold_kind;
                r_out_value <= r_hold_value;
                r_out_cut   <= r_hold_cut;
                r_out_last  <= 1'b0;
            end
            r_hold_kind  <= i_push.kind;
            r_hold_value <= i_push.value;
            r_hold_cut   <= i_push.cut;
        end else if (i_push.flush && r_hold_v && out_free) begin
            r_out_kind  <= r_hold_kind;
            r_out_value <= r_hold_value;
            r_out_cut   <= r_hold_cut;
            r_out_last  <= 1'b1;
        end
    end

    assign o_st.push_ready = push_ok;
    assign o_st.flush_done = flush_ok;
    assign o_st.hold_valid = r_hold_v;

    assign o_tvalid = r_out_v;
    assign o_tdata  = r_out_value;
    assign o_tuser  = {r_out_cut, r_out_kind};
    assign o_tlast  = r_out_last;

`ifndef SYNTHESIS
    // A flushed result always leaves marked last
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.flush && r_hold_v && out_free && !i_push.valid) |=> (r_out_v && r_out_last))
        else $error("flushed result not marked last");
    // Sequencer never pushes and flushes together
    a_push_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && i_push.flush))
        else $error("push and flush at once");
    // A push over a full hold moves the older result out
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && push_ok && r_hold_v) |=> (r_out_v && !r_out_last && r_hold_v))
        else $error("held result lost");
`endif

endmodule

// ===== hdl/sse_event_stream_parser_core.sv =====
// Top level: SSE byte parser sequencer with shared byte buffer and output stage.
//
//  channel  | dir | tdata            | tuser                      | tlast
//  s_axis   | in  | [7:0] byte_req   | [0] req_type               | -
//  m_axis   | out | [7:0] value      | [1:0] kind, [2] cut        | last
//
//  An ordinary byte passes S_BYTE and S_FLUSH before ready again, after S_CR
//  when a held CR is replayed first; a lone CR passes S_FLUSH, a restart stays
//  in S_IDLE. A dispatching blank line emits the default or stored name, then
//  the stored id, each stored byte read via the single registered read port of
//  the byte buffer, then the end marker. Every result leaves through one output
//  register; a stalled m_axis holds the sequencer. Reset and a restart clear the parser state.
module sse_event_stream_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_req
    input  logic       s_axis_tuser,   // [0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] value
    output logic [2:0] m_axis_tuser,   // [1:0] kind, [2] cut
    output logic       m_axis_tlast
);

    localparam int NW = sep_pkg::NLEN_W;
    localparam int IW = sep_pkg::ILEN_W;
    localparam int XW = sep_pkg::IDX_W;
    localparam int AW = sep_pkg::MEM_AW;

    sep_pkg::t_state r_state, n_state;
    sep_pkg::t_phase r_phase, n_phase;
    sep_pkg::t_field r_field, n_field;
    logic [7:0]      r_c, n_c;
    logic            r_pcr, n_pcr;
    sep_pkg::t_fname r_fn;
    logic [2:0]      r_fn_len, n_fn_len;
    logic [NW-1:0]   r_nlen, n_nlen;
    logic            r_act, n_act;
    logic [IW-1:0]   r_ilen, n_ilen;
    logic [IW-1:0]   r_slen, n_slen;
    logic            r_nul, n_nul;
    logic            r_saw, n_saw;
    logic            r_cut, n_cut;
    logic            r_icut, n_icut;
    logic            r_scut, n_scut;
    logic [XW-1:0]   r_idx, n_idx;

    sep_pkg::t_push  push;
    sep_pkg::t_ost   ost;
    logic            go;
    logic            fn_we;
    logic [2:0]      fn_widx;
    logic [7:0]      b;
    logic            do_begin;
    sep_pkg::t_field beg_f;
    logic            do_value;
    sep_pkg::t_field cls;
    logic            mem_we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [7:0]      rdata;
    logic [XW:0]     idx_inc;
    logic            swap_id;

    assign cls     = sep_pkg::classify(r_fn, r_fn_len);
    assign b       = (r_state == sep_pkg::S_CR) ? sep_pkg::CHR_CR : r_c;
    assign idx_inc = {1'b0, r_idx} + 1'b1;
    assign s_axis_tready = (r_state == sep_pkg::S_IDLE);

    // Read address follows the dispatch index
    always_comb begin
        if (r_state == sep_pkg::S_IRD || r_state == sep_pkg::S_IEM) begin
            raddr = AW'(r_act ? sep_pkg::ID_MAX : 0) + AW'(r_idx);
        end else begin
            raddr = AW'(sep_pkg::NAME_BASE) + AW'(r_idx);
        end
    end

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_field  = r_field;
        n_c      = r_c;
        n_pcr    = r_pcr;
        n_fn_len = r_fn_len;
        n_nlen   = r_nlen;
        n_act    = r_act;
        n_ilen   = r_ilen;
        n_slen   = r_slen;
        n_nul    = r_nul;
        n_saw    = r_saw;
        n_cut    = r_cut;
        n_icut   = r_icut;
        n_scut   = r_scut;
        n_idx    = r_idx;
        push     = '0;
        fn_we    = 1'b0;
        fn_widx  = r_fn_len;
        mem_we   = 1'b0;
        waddr    = '0;
        do_begin = 1'b0;
        beg_f    = sep_pkg::FLD_NONE;
        do_value = 1'b0;
        swap_id  = 1'b0;

        case (r_state)
            sep_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == sep_pkg::REQ_RESTART) begin
                        n_phase  = sep_pkg::PH_START;
                        n_field  = sep_pkg::FLD_NONE;
                        n_pcr    = 1'b0;
                        n_fn_len = '0;
                        n_nlen   = '0;
                        n_act    = 1'b0;
                        n_ilen   = '0;
                        n_slen   = '0;
                        n_nul    = 1'b0;
                        n_saw    = 1'b0;
                        n_cut    = 1'b0;
                        n_icut   = 1'b0;
                        n_scut   = 1'b0;
                    end else begin
                        n_c = s_axis_tdata;
                        if (s_axis_tdata == sep_pkg::CHR_LF) begin
                            n_pcr   = 1'b0;
                            n_state = sep_pkg::S_LEND;
                        end else if (r_pcr) begin
                            n_pcr   = 1'b0;
                            n_state = sep_pkg::S_CR;
                        end else if (s_axis_tdata == sep_pkg::CHR_CR) begin
                            n_pcr   = 1'b1;
                            n_state = sep_pkg::S_FLUSH;
                        end else begin
                            n_state = sep_pkg::S_BYTE;
                        end
                    end
                end
            end
            sep_pkg::S_CR, sep_pkg::S_BYTE: begin
                case (r_phase)
                    sep_pkg::PH_START: begin
                        if (b == sep_pkg::CHR_COLON) begin
                            n_phase = sep_pkg::PH_SKIP;
                        end else begin
                            fn_we    = 1'b1;
                            fn_widx  = 3'd0;
                            n_fn_len = 3'd1;
                            n_phase  = sep_pkg::PH_NAME;
                        end
                    end
                    sep_pkg::PH_NAME: begin
                        if (b == sep_pkg::CHR_COLON) begin
                            do_begin = 1'b1;
                            beg_f    = cls;
                            n_phase  = sep_pkg::PH_VSTART;
                        end else if (r_fn_len < 3'(sep_pkg::FN_MAX)) begin
                            fn_we    = 1'b1;
                            n_fn_len = r_fn_len + 3'd1;
                        end else begin
                            n_fn_len = sep_pkg::FN_LONG;
                        end
                    end
                    sep_pkg::PH_VSTART: begin
                        n_phase  = sep_pkg::PH_VALUE;
                        do_value = (b != sep_pkg::CHR_SPACE);
                    end
                    sep_pkg::PH_VALUE: begin
                        do_value = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (r_state == sep_pkg::S_CR) begin
                    if (r_c == sep_pkg::CHR_CR) begin
                        n_pcr   = 1'b1;
                        n_state = sep_pkg::S_FLUSH;
                    end else begin
                        n_state = sep_pkg::S_BYTE;
                    end
                end else begin
                    n_state = sep_pkg::S_FLUSH;
                end
            end
            sep_pkg::S_LEND: begin
                if (r_phase == sep_pkg::PH_START) begin
                    if (r_saw) begin
                        n_idx   = '0;
                        n_state = (r_nlen == '0) ? sep_pkg::S_MSG : sep_pkg::S_NRD;
                    end else begin
                        n_nlen  = '0;
                        n_cut   = 1'b0;
                        n_saw   = 1'b0;
                        n_state = sep_pkg::S_FLUSH;
                    end
                end else begin
                    if (r_phase == sep_pkg::PH_NAME) begin
                        do_begin = 1'b1;
                        beg_f    = cls;
                    end
                    swap_id = 1'b1;
                    n_state = sep_pkg::S_FLUSH;
                end
            end
            sep_pkg::S_MSG: begin
                push.valid = 1'b1;
                push.kind  = sep_pkg::K_NAME;
                push.value = sep_pkg::msg_char(r_idx[2:0]);
                n_idx      = XW'(idx_inc);
                if (r_idx == XW'(sep_pkg::MSG_LAST)) begin
                    n_idx   = '0;
                    n_state = (r_ilen == '0) ? sep_pkg::S_END : sep_pkg::S_IRD;
                end
            end
            sep_pkg::S_NRD: begin
                n_state = sep_pkg::S_NEM;
            end
            sep_pkg::S_NEM: begin
                push.valid = 1'b1;
                push.kind  = sep_pkg::K_NAME;
                push.value = rdata;
                n_idx      = XW'(idx_inc);
                n_state    = sep_pkg::S_NRD;
                if (idx_inc == (XW+1)'(r_nlen)) begin
                    n_idx   = '0;
                    n_state = (r_ilen == '0) ? sep_pkg::S_END : sep_pkg::S_IRD;
                end
            end
            sep_pkg::S_IRD: begin
                n_state = sep_pkg::S_IEM;
            end
            sep_pkg::S_IEM: begin
                push.valid = 1'b1;
                push.kind  = sep_pkg::K_ID;
                push.value = rdata;
                n_idx      = XW'(idx_inc);
                n_state    = sep_pkg::S_IRD;
                if (idx_inc == (XW+1)'(r_ilen)) begin
                    n_idx   = '0;
                    n_state = sep_pkg::S_END;
                end
            end
            sep_pkg::S_END: begin
                push.valid = 1'b1;
                push.kind  = sep_pkg::K_END;
                push.value = sep_pkg::CHR_NUL;
                push.cut   = r_cut | r_icut;
                n_nlen     = '0;
                n_cut      = 1'b0;
                n_saw      = 1'b0;
                n_state    = sep_pkg::S_FLUSH;
            end
            sep_pkg::S_FLUSH: begin
                push.flush = 1'b1;
                if (ost.flush_done) begin
                    n_state = sep_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sep_pkg::S_IDLE;
            end
        endcase

        // Open a field value
        if (do_begin) begin
            n_field = beg_f;
            case (beg_f)
                sep_pkg::FLD_EVENT: begin
                    n_nlen = '0;
                    n_cut  = 1'b0;
                end
                sep_pkg::FLD_DATA: begin
                    if (r_saw) begin
                        push.valid = 1'b1;
                        push.kind  = sep_pkg::K_DATA;
                        push.value = sep_pkg::CHR_LF;
                    end
                    n_saw = 1'b1;
                end
                sep_pkg::FLD_ID: begin
                    n_slen = '0;
                    n_nul  = 1'b0;
                    n_scut = 1'b0;
                end
                default: begin
                end
            endcase
        end

        // Take one value byte
        if (do_value) begin
            case (r_field)
                sep_pkg::FLD_DATA: begin
                    push.valid = 1'b1;
                    push.kind  = sep_pkg::K_DATA;
                    push.value = b;
                end
                sep_pkg::FLD_EVENT: begin
                    if (r_nlen < NW'(sep_pkg::NAME_MAX)) begin
                        mem_we = 1'b1;
                        waddr  = AW'(sep_pkg::NAME_BASE) + AW'(r_nlen);
                        n_nlen = r_nlen + 1'b1;
                    end else begin
                        n_cut = 1'b1;
                    end
                end
                sep_pkg::FLD_ID: begin
                    if (b == sep_pkg::CHR_NUL) begin
                        n_nul = 1'b1;
                    end
                    if (r_slen < IW'(sep_pkg::ID_MAX)) begin
                        mem_we = 1'b1;
                        waddr  = AW'(r_act ? 0 : sep_pkg::ID_MAX) + AW'(r_slen);
                        n_slen = r_slen + 1'b1;
                    end else begin
                        n_scut = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Close the line, promote a clean staged id
        if (swap_id) begin
            if (n_field == sep_pkg::FLD_ID && !n_nul) begin
                n_act  = ~r_act;
                n_ilen = n_slen;
                n_icut = n_scut;
            end
            n_phase = sep_pkg::PH_START;
            n_field = sep_pkg::FLD_NONE;
        end
    end

    // Advance only when a wanted result fits in the output stage
    assign go = !push.valid || ost.push_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sep_pkg::S_IDLE;
            r_phase  <= sep_pkg::PH_START;
            r_field  <= sep_pkg::FLD_NONE;
            r_pcr    <= 1'b0;
            r_fn_len <= '0;
            r_nlen   <= '0;
            r_act    <= 1'b0;
            r_ilen   <= '0;
            r_slen   <= '0;
            r_nul    <= 1'b0;
            r_saw    <= 1'b0;
            r_cut    <= 1'b0;
            r_icut   <= 1'b0;
            r_scut   <= 1'b0;
            r_idx    <= '0;
        end else if (go) begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_field  <= n_field;
            r_pcr    <= n_pcr;
            r_fn_len <= n_fn_len;
            r_nlen   <= n_nlen;
            r_act    <= n_act;
            r_ilen   <= n_ilen;
            r_slen   <= n_slen;
            r_nul    <= n_nul;
            r_saw    <= n_saw;
            r_cut    <= n_cut;
            r_icut   <= n_icut;
            r_scut   <= n_scut;
            r_idx    <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_c <= n_c;
            if (fn_we) begin
                r_fn[fn_widx] <= b;
            end
        end
    end

    sep_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we && go),
        .i_waddr (waddr),
        .i_wdata (b),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sep_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_st     (ost),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // Back to idle only with every result of the item handed off
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sep_pkg::S_IDLE) |-> !ost.hold_valid)
        else $error("idle with a held result");
    // Stored lengths stay within capacity
    a_name_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nlen <= NW'(sep_pkg::NAME_MAX))
        else $error("event name length overflow");
    a_id_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ilen <= IW'(sep_pkg::ID_MAX)) && (r_slen <= IW'(sep_pkg::ID_MAX)))
        else $error("id length overflow");
    // Dispatch only runs with data pending
    a_dispatch_saw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sep_pkg::S_END) |-> r_saw)
        else $error("end marker without data");
`endif

endmodule

// ===== verif/tb_sse_event_stream_parser_core.sv =====
// Self-checking testbench for the SSE event stream parser core.
module tb_sse_event_stream_parser_core;
    import sep_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       cut;
        logic       last;
    } t_sse_out;

    // Track parser state and queue the beats each byte should produce
    class sse_scoreboard;
        t_phase     phase;
        logic       held_cr;
        logic [7:0] fname [FN_MAX];
        logic [2:0] fname_len;
        t_field     fld;
        logic [7:0] ename [NAME_MAX];
        int         ename_len;
        logic [7:0] idb [2][ID_MAX];
        logic       bank;
        int         id_len, stage_len;
        logic       id_nul, seen_data, name_cut, id_cut, stage_cut;
        t_sse_out   pending [$];
        t_sse_out   step [$];
        int         errors;

        function void clear();
            phase = PH_START; held_cr = 0; fname_len = 0; fld = FLD_NONE;
            ename_len = 0; bank = 0; id_len = 0; stage_len = 0; id_nul = 0;
            seen_data = 0; name_cut = 0; id_cut = 0; stage_cut = 0;
        endfunction

        function void push(logic [1:0] k, logic [7:0] v, logic c);
            t_sse_out r;
            r.kind = k; r.value = v; r.cut = c; r.last = 0;
            step.insert(step.size(), r);
        endfunction

        function t_field field_of();
            if (fname_len == 5 && fname[0] == "e" && fname[1] == "v" && fname[2] == "e"
                && fname[3] == "n" && fname[4] == "t") return FLD_EVENT;
            if (fname_len == 4 && fname[0] == "d" && fname[1] == "a" && fname[2] == "t"
                && fname[3] == "a") return FLD_DATA;
            if (fname_len == 2 && fname[0] == "i" && fname[1] == "d") return FLD_ID;
            return FLD_NONE;
        endfunction

        function void open_value(t_field f);
            fld = f;
            if (f == FLD_EVENT) begin
                ename_len = 0; name_cut = 0;
            end else if (f == FLD_DATA) begin
                if (seen_data) push(K_DATA, CHR_LF, 0);
                seen_data = 1;
            end else if (f == FLD_ID) begin
                stage_len = 0; id_nul = 0; stage_cut = 0;
            end
        endfunction

        function void value_char(logic [7:0] c);
            if (fld == FLD_DATA) push(K_DATA, c, 0);
            else if (fld == FLD_EVENT) begin
                if (ename_len < NAME_MAX) ename[ename_len++] = c;
                else name_cut = 1;
            end else if (fld == FLD_ID) begin
                if (c == CHR_NUL) id_nul = 1;
                if (stage_len < ID_MAX) idb[~bank][stage_len++] = c;
                else stage_cut = 1;
            end
        endfunction

        function void line_char(logic [7:0] c);
            if (phase == PH_START) begin
                if (c == CHR_COLON) begin
                    phase = PH_SKIP;
                    return;
                end
                fname_len = 0;
                phase = PH_NAME;
            end
            case (phase)
                PH_NAME: begin
                    if (c == CHR_COLON) begin
                        open_value(field_of());
                        phase = PH_VSTART;
                    end else if (fname_len < FN_MAX) fname[fname_len++] = c;
                    else fname_len = FN_LONG;
                end
                PH_VSTART: begin
                    phase = PH_VALUE;
                    if (c != CHR_SPACE) value_char(c);
                end
                PH_VALUE: value_char(c);
                default: ;
            endcase
        endfunction

        function void end_line();
            if (phase == PH_START) begin
                if (seen_data) begin
                    if (ename_len == 0)
                        for (int i = 0; i < 7; i++) push(K_NAME, msg_lit(i), 0);
                    else
                        for (int i = 0; i < ename_len; i++) push(K_NAME, ename[i], 0);
                    for (int i = 0; i < id_len; i++) push(K_ID, idb[bank][i], 0);
                    push(K_END, 8'h00, name_cut | id_cut);
                end
                ename_len = 0; name_cut = 0; seen_data = 0;
                return;
            end
            if (phase == PH_NAME) open_value(field_of());
            if (phase != PH_SKIP && fld == FLD_ID && !id_nul) begin
                bank = ~bank; id_len = stage_len; id_cut = stage_cut;
            end
            phase = PH_START;
            fld = FLD_NONE;
        endfunction

        function logic [7:0] msg_lit(int i);
            string s;
            s = "message";
            return s[i];
        endfunction

        // Note one accepted input beat
        function void note_input(logic restart, logic [7:0] c);
            step.delete();
            if (restart) begin
                clear();
                return;
            end
            if (c == CHR_LF) begin
                held_cr = 0;
                end_line();
            end else begin
                if (held_cr) begin
                    held_cr = 0;
                    line_char(CHR_CR);
                end
                if (c == CHR_CR) held_cr = 1;
                else line_char(c);
            end
            if (step.size() > 0) step[$].last = 1;
            foreach (step[i]) pending.insert(pending.size(), step[i]);
        endfunction

        // Check one accepted output beat
        function void check_result(t_sse_out got);
            t_sse_out exp_r;
            if (pending.size() == 0) begin
                report_err($sformatf("unexpected beat kind=%0d value=%h", got.kind, got.value));
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind) report_err($sformatf("kind %0d, want %0d",
                got.kind, exp_r.kind));
            if (got.value !== exp_r.value) report_err($sformatf("value %h, want %h",
                got.value, exp_r.value));
            if (got.cut !== exp_r.cut) report_err($sformatf("cut %b, want %b",
                got.cut, exp_r.cut));
            if (got.last !== exp_r.last) report_err($sformatf("last %b, want %b",
                got.last, exp_r.last));
        endfunction

        function void report_err(string msg);
            errors++;
            if (errors <= 40) $display("ERROR: %s", msg);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] byte_req
    logic       s_axis_tuser;   // [0] req_type
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] value
    logic [2:0] m_axis_tuser;   // [1:0] kind, [2] cut
    logic       m_axis_tlast;

    sse_scoreboard sb;
    logic [8:0]    stim [$];
    logic          long_hold;
    logic          in_done;
    int            idle_cycles;

    sse_event_stream_parser_core dut (.*);

    // Clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Add a string of stream bytes
    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) stim.insert(stim.size(), {REQ_BYTE, s[i]});
    endtask

    task automatic add_rand_bytes(int n, int lo, int hi);
        for (int i = 0; i < n; i++)
            stim.insert(stim.size(), {REQ_BYTE, 8'($urandom_range(hi, lo))});
    endtask

    // Build one random event block, mostly well formed
    task automatic add_rand_event();
        int n;
        n = $urandom_range(2, 0);
        if ($urandom_range(3, 0) == 0) begin
            add_str("event:");
            add_rand_bytes($urandom_range(20, 0), 8'h21, 8'h7e);
            add_str("\n");
        end
        for (int i = 0; i < n + 1; i++) begin
            add_str($urandom_range(1, 0) ? "data: " : "data:");
            add_rand_bytes($urandom_range(4, 0), 8'h20, 8'h7e);
            add_str($urandom_range(3, 0) == 0 ? "\r\n" : "\n");
        end
        case ($urandom_range(7, 0))
            0: begin
                add_str("id:");
                add_rand_bytes($urandom_range(36, 0), 8'h30, 8'h7a);
                add_str("\n");
            end
            1: add_str(": note\n");
            2: add_rand_bytes($urandom_range(6, 1), 8'h00, 8'hff);
            3: stim.insert(stim.size(), {REQ_RESTART, 8'($urandom_range(255, 0))});
            4: add_str("retry: 10\n");
            default: ;
        endcase
        add_str("\n");
    endtask

    // Feed input beats in bursts with random gaps
    task automatic drive_inputs();
        int burst;
        int gap;
        burst = 0;
        while (stim.size() > 0) begin
            if (burst == 0) begin
                gap = $urandom_range(4, 0);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(30, 1);
            end
            s_axis_tvalid <= 1'b1;
            {s_axis_tuser, s_axis_tdata} <= stim[0];
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            void'(stim.pop_front());
            burst--;
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Score accepted beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result({m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2],
                    m_axis_tlast});
        end
    end

    // Receiver stall pattern, with a long hold when requested
    always @(posedge i_clk) begin
        if (long_hold) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(7, 0) < 5) || (($urandom_range(255, 0)) < 40);
    end

    // Watchdog: cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n || long_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb_sse_event_stream_parser_core: FAIL");
            $finish;
        end
    end

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        long_hold = 1'b0;
        in_done = 1'b0;
        idle_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default name, CR handling, comment, id with NUL, cut name
        add_str("data:\xff\r\n\n");
        add_str(":x\nid:");
        stim.insert(stim.size(), {REQ_BYTE, CHR_NUL});
        add_str("\n\rdata: a\r\n\n");
        stim.insert(stim.size(), {REQ_RESTART, 8'h00});
        add_str("eventz\nid\nevent:ABCDEFGHIJKLMNOPQ\ndata\n\n");
        drive_inputs();

        // Wait for the queue to drain with the sender paused
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        // Long receiver hold while the sender keeps offering bytes
        add_str("id:");
        add_rand_bytes(40, 8'h41, 8'h5a);
        add_str("\nevent:q\ndata:zz\n\n");
        fork
            drive_inputs();
            begin
                long_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold <= 1'b0;
            end
        join

        // Random part
        while (stim.size() < 200) add_rand_event();
        drive_inputs();
        in_done = 1'b1;

        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_sse_event_stream_parser_core: PASS");
        else
            $display("tb_sse_event_stream_parser_core: FAIL");
        $finish;
    end
endmodule
